>>> design/egsv_pkg.sv
// shared types, constants and codes for the elgamal signature checker
package egsv_pkg;

   localparam int MOD_BITS = 16;
   localparam int EXP_BITS = 16;
   localparam int OUT_BITS = 16;
   // multiplier operand width: wide enough for a full modulus and a full signature word
   localparam int OPW_BITS = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
   localparam int CNT_BITS = $clog2(OPW_BITS + 1);

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CFG_MODULUS    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CFG_GENERATOR  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CFG_PUBLIC_KEY = 2'd2;

   localparam logic [MOD_BITS-1:0] MODULUS_RESET    = MOD_BITS'(23);
   localparam logic [MOD_BITS-1:0] GENERATOR_RESET  = MOD_BITS'(2);
   localparam logic [MOD_BITS-1:0] PUBLIC_KEY_RESET = MOD_BITS'(1);

   localparam int REQ_DATA_BITS = 3 * EXP_BITS;
   localparam int RSP_FIELD_BITS = 1 + 2 * OUT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BASE,
      S_BWAIT,
      S_STEP,
      S_MWAIT,
      S_SQ,
      S_SWAIT,
      S_POWEND,
      S_LWAIT,
      S_DONE
   } state_type;

   // which power is being worked out
   typedef enum logic [1:0] {
      P_YA,
      P_AB,
      P_GM
   } phase_type;

   typedef enum logic [1:0] {
      MUL_REDUCE,
      MUL_RES_SQ,
      MUL_SQ_SQ,
      MUL_RES_YA
   } mul_op_type;

   typedef struct packed {
      logic       capture;
      logic       clear_out;
      logic       mul_start;
      mul_op_type mul_op;
      phase_type  phase;
      logic       load_exp;
      logic       shift_exp;
      logic       init_res;
      logic       wr_sq;
      logic       wr_res;
      logic       save_ya;
      logic       save_lhs;
      logic       save_rhs;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic p_small;
      logic exp_zero;
      logic exp_lsb;
      logic exp_rest_zero;
   } stat_type;

endpackage

>>> design/egsv_mulmod.sv
// interleaved modular multiplier, one multiplier bit per cycle
module egsv_mulmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [egsv_pkg::MOD_BITS-1:0]  x,
   input  logic [egsv_pkg::OPW_BITS-1:0]  y,
   input  logic [egsv_pkg::MOD_BITS-1:0]  p,
   output logic                           done,
   output logic [egsv_pkg::MOD_BITS-1:0]  prod
);
   import egsv_pkg::*;

   localparam int T_BITS = MOD_BITS + 2;

   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [OPW_BITS-1:0] y_ff, y_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic [T_BITS-1:0] t0, t1, t2, pe;

   // r = 2r + bit*x, then at most two subtractions of p keep r below p
   always_comb begin
      pe = T_BITS'(p);
      t0 = {1'b0, r_ff, 1'b0} + (y_ff[OPW_BITS-1] ? T_BITS'(x_ff) : '0);
      t1 = (t0 >= pe) ? t0 - pe : t0;
      t2 = (t1 >= pe) ? t1 - pe : t1;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = x;
         y_in   = y;
         r_in   = '0;
         cnt_in = CNT_BITS'(OPW_BITS);
      end else if (cnt_ff != '0) begin
         y_in    = {y_ff[OPW_BITS-2:0], 1'b0};
         r_in    = t2[MOD_BITS-1:0];
         cnt_in  = cnt_ff - CNT_BITS'(1);
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign prod = r_ff;

endmodule

>>> design/egsv_datapath.sv
// operand registers, configuration registers, multiplier and result register
module egsv_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [egsv_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [egsv_pkg::MOD_BITS-1:0]       csr_data,
   input  logic [egsv_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  egsv_pkg::cmd_type                   cmd,
   output egsv_pkg::stat_type                  stat,
   output logic [egsv_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import egsv_pkg::*;

   logic [MOD_BITS-1:0] mod_ff, gen_ff, pub_ff;
   logic [EXP_BITS-1:0] msg_ff, sa_ff, sb_ff;
   logic [EXP_BITS-1:0] exp_ff;
   logic [MOD_BITS-1:0] res_ff, sq_ff, ya_ff, lhs_ff, rhs_ff;
   logic                o_valid_ff;
   logic [OUT_BITS-1:0] o_lhs_ff, o_rhs_ff;

   logic [MOD_BITS-1:0] mul_x;
   logic [OPW_BITS-1:0] mul_y, base;
   logic [EXP_BITS-1:0] exp_src;
   logic                mul_done;
   logic [MOD_BITS-1:0] mul_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
         gen_ff <= GENERATOR_RESET;
         pub_ff <= PUBLIC_KEY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_MODULUS:    mod_ff <= csr_data;
            CFG_GENERATOR:  gen_ff <= csr_data;
            CFG_PUBLIC_KEY: pub_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cmd.phase)
         P_YA: begin
            base    = OPW_BITS'(pub_ff);
            exp_src = sa_ff;
         end
         P_AB: begin
            base    = OPW_BITS'(sa_ff);
            exp_src = sb_ff;
         end
         default: begin
            base    = OPW_BITS'(gen_ff);
            exp_src = msg_ff;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.mul_op)
         MUL_REDUCE: begin
            mul_x = MOD_BITS'(1);
            mul_y = base;
         end
         MUL_RES_SQ: begin
            mul_x = res_ff;
            mul_y = OPW_BITS'(sq_ff);
         end
         MUL_SQ_SQ: begin
            mul_x = sq_ff;
            mul_y = OPW_BITS'(sq_ff);
         end
         default: begin
            mul_x = res_ff;
            mul_y = OPW_BITS'(ya_ff);
         end
      endcase
   end

   egsv_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .x     (mul_x),
      .y     (mul_y),
      .p     (mod_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         msg_ff <= req_tdata[EXP_BITS-1:0];
         sa_ff  <= req_tdata[2*EXP_BITS-1:EXP_BITS];
         sb_ff  <= req_tdata[3*EXP_BITS-1:2*EXP_BITS];
      end
      if (cmd.load_exp) begin
         exp_ff <= exp_src;
      end else if (cmd.shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.init_res) begin
         res_ff <= MOD_BITS'(1);
      end else if (cmd.wr_res) begin
         res_ff <= mul_prod;
      end
      if (cmd.wr_sq) begin
         sq_ff <= mul_prod;
      end
      if (cmd.save_ya) begin
         ya_ff <= res_ff;
      end
      // a modulus below two makes every value zero
      if (cmd.clear_out) begin
         lhs_ff <= '0;
         rhs_ff <= '0;
      end else begin
         if (cmd.save_lhs) begin
            lhs_ff <= mul_prod;
         end
         if (cmd.save_rhs) begin
            rhs_ff <= res_ff;
         end
      end
      if (cmd.load_out) begin
         o_valid_ff <= (lhs_ff == rhs_ff);
         o_lhs_ff   <= OUT_BITS'(lhs_ff);
         o_rhs_ff   <= OUT_BITS'(rhs_ff);
      end
   end

   always_comb begin
      stat.mul_done      = mul_done;
      stat.p_small       = (mod_ff < MOD_BITS'(2));
      stat.exp_zero      = (exp_ff == '0);
      stat.exp_lsb       = exp_ff[0];
      stat.exp_rest_zero = ((exp_ff >> 1) == '0);
   end

   assign rsp_tdata = RSP_DATA_BITS'({o_rhs_ff, o_lhs_ff, o_valid_ff});

endmodule

>>> design/egsv_ctrl.sv
// sequencer for the three square-and-multiply powers and the final product
module egsv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  egsv_pkg::stat_type  stat,
   output egsv_pkg::cmd_type   cmd
);
   import egsv_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_YA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cmd        = '0;
      cmd.phase  = phase_ff;
      cmd.mul_op = MUL_REDUCE;
      req_tready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               phase_in    = P_YA;
               if (stat.p_small) begin
                  cmd.clear_out = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_BASE;
               end
            end
         end
         S_BASE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_REDUCE;
            cmd.load_exp  = 1'b1;
            cmd.init_res  = 1'b1;
            state_in      = S_BWAIT;
         end
         S_BWAIT: begin
            if (stat.mul_done) begin
               cmd.wr_sq = 1'b1;
               state_in  = S_STEP;
            end
         end
         S_STEP: begin
            if (stat.exp_zero) begin
               state_in = S_POWEND;
            end else if (stat.exp_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_RES_SQ;
               state_in      = S_MWAIT;
            end else begin
               state_in = S_SQ;
            end
         end
         S_MWAIT: begin
            if (stat.mul_done) begin
               cmd.wr_res = 1'b1;
               state_in   = S_SQ;
            end
         end
         S_SQ: begin
            cmd.shift_exp = 1'b1;
            // last exponent bit done: the final squaring is not needed
            if (stat.exp_rest_zero) begin
               state_in = S_POWEND;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_SQ_SQ;
               state_in      = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (stat.mul_done) begin
               cmd.wr_sq = 1'b1;
               state_in  = S_STEP;
            end
         end
         S_POWEND: begin
            unique case (phase_ff)
               P_YA: begin
                  cmd.save_ya = 1'b1;
                  phase_in    = P_AB;
                  state_in    = S_BASE;
               end
               P_AB: begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_op    = MUL_RES_YA;
                  state_in      = S_LWAIT;
               end
               P_GM: begin
                  cmd.save_rhs = 1'b1;
                  state_in     = S_DONE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_LWAIT: begin
            if (stat.mul_done) begin
               cmd.save_lhs = 1'b1;
               phase_in     = P_GM;
               state_in     = S_BASE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> design/elgamal_signature_verify_top.sv
// top level of the elgamal signature checker
//
// usage: write modulus p (index 0), generator g (index 1) and public key y
// (index 2) over the csr channel while the block is idle; csr_ready is always
// high. each transfer on the req channel carries message m, signature word a
// and signature word b. for each one the rsp channel returns one transfer with
// lhs = y^a * a^b mod p, rhs = g^m mod p and a match flag.
// timing: one item is worked on at a time. the three powers and the final
// product run on a single shared modular multiplier that takes one multiplier
// bit per cycle. a power costs one base reduction plus one product per set
// exponent bit and one squaring per further bit.
// a modulus below two gives zeros and a match without running the powers.
// req_tready rises again once the result sits in the output register, so the
// next item may start while the previous result still waits to be taken; a
// stalled receiver holds the result and the block waits before loading another.
// reset returns the registers to p = 23, g = 2, y = 1 and empties the block.
module elgamal_signature_verify_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // message [15:0], sig_first [31:16], sig_second [47:32]
   input  logic [egsv_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // valid_res [0], lhs_value [16:1], rhs_value [32:17], zero fill above
   output logic [egsv_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [egsv_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [egsv_pkg::MOD_BITS-1:0]       csr_data
);
   import egsv_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   egsv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   egsv_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   // req_tready drops once an item has been taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous one still in work");

   // the match flag agrees with the two values it reports
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[16:1] == rsp_tdata[32:17])))
      else $error("match flag disagrees with reported values");

   // a product cannot finish in the cycle after it was started
   assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !stat.mul_done)
      else $error("multiplier finished too early");
`endif

endmodule
